>>> rtl/core/dc_block_envelope_limiter_top_assert.svh
// Assertion helpers for the output conditioner.
`ifndef DC_BLOCK_ENVELOPE_LIMITER_TOP_ASSERT_SVH
`define DC_BLOCK_ENVELOPE_LIMITER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DBEL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DBEL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/dbel_pkg.sv
package dbel_pkg;

    // Fixed sample and state formats
    localparam int SAMPLE_FRAC  = 16;
    localparam int STATE_EXTRA  = 24;
    localparam int RED_SHIFT    = 16;
    localparam int GAIN_06_Q16  = 39322;
    localparam int GAIN_W       = 16;
    localparam int DIV_STEPS    = 16;
    localparam int VOL_W        = 16;
    localparam int OUT_W        = 16;
    localparam int CFG_IDX_W    = 3;

    localparam logic signed [OUT_W-1:0] OUT_POS_LIM = 16'sh7FFF;
    localparam logic signed [OUT_W-1:0] OUT_NEG_LIM = 16'sh8000;

    // Register reset values
    localparam int RST_DC_COEF      = 190;
    localparam int RST_ATTACK_COEF  = 75920;
    localparam int RST_RELEASE_COEF = 1902;
    localparam int RST_OUT_VOLUME   = 32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DC_COEF      = 3'd0,
        REG_ATTACK_COEF  = 3'd1,
        REG_RELEASE_COEF = 3'd2,
        REG_OUT_VOLUME   = 3'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DC_MUL,
        ST_DC_ADD,
        ST_ABS,
        ST_ENV_SET,
        ST_ENV_MUL,
        ST_ENV_ADD,
        ST_ENV_FLOOR,
        ST_DIV_PREP,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

>>> rtl/core/dbel_sample_in_if.sv
interface dbel_sample_in_if #(
    parameter int SAMPLE_WIDTH = 24
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

>>> rtl/core/dbel_sample_out_if.sv
interface dbel_sample_out_if
    import dbel_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

>>> rtl/core/dc_block_envelope_limiter_top.sv
// Each sample runs the two bit-serial coefficient multiplies (DC, then envelope
// with the attack or release coefficient) and the 16-step restoring divide; the
// divide stops after its first compare when the limiter clips to full scale. A new
// sample is accepted only in idle, once the previous result is in the output register.
// Reset: rst_n async active low; coefficients and volume to defaults, DC and
// envelope state to zero, output register empty.
`include "dc_block_envelope_limiter_top_assert.svh"

module dc_block_envelope_limiter_top
    import dbel_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [COEF_FRAC_BITS-1:0] cfg_wdata,
    dbel_sample_in_if.sink            feed,
    dbel_sample_out_if.source         result
);

    // State format: SAMPLE_FRAC + STATE_EXTRA fraction bits.
    localparam int S_W    = SAMPLE_WIDTH + STATE_EXTRA;   // DC level, signed
    localparam int A_W    = S_W + 1;                      // |x - dc| and envelope, unsigned
    localparam int D_W    = S_W + 2;                      // multiplier operand, signed
    localparam int ER_W   = A_W - RED_SHIFT;              // reduced level / envelope
    localparam int NUM_W  = ER_W + GAIN_W;                // divide numerator
    localparam int ACC_W  = VOL_W + DIV_STEPS - 1;        // quotient times volume
    localparam int CNT_W  = $clog2(COEF_FRAC_BITS);

    localparam logic [A_W-1:0] ENV_ONE = A_W'(1) << (SAMPLE_FRAC + STATE_EXTRA);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COEF_FRAC_BITS-1:0] dc_coef_reg;
    logic [COEF_FRAC_BITS-1:0] attack_coef_reg;
    logic [COEF_FRAC_BITS-1:0] release_coef_reg;
    logic [VOL_W-1:0]          volume_reg;

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [S_W-1:0]     x_reg, x_next;
    logic signed [S_W-1:0]     dc_reg, dc_next;
    logic [A_W-1:0]            env_reg, env_next;
    logic [A_W-1:0]            a_reg, a_next;
    logic                      neg_reg, neg_next;
    logic signed [D_W-1:0]     md_reg, md_next;       // multiplicand
    logic signed [D_W-1:0]     macc_reg, macc_next;   // shift-right accumulator
    logic [COEF_FRAC_BITS-1:0] coef_sh_reg, coef_sh_next;
    logic [NUM_W-1:0]          rem_reg, rem_next;
    logic [NUM_W-1:0]          dsh_reg, dsh_next;
    logic [ACC_W-1:0]          gacc_reg, gacc_next;
    logic [VOL_W-1:0]          g_reg, g_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]   out_data_reg, out_data_next;

    // Combinational helpers
    logic signed [S_W-1:0]     x_new;
    logic signed [D_W-1:0]     x_ext;
    logic signed [D_W-1:0]     dc_ext;
    logic signed [D_W:0]       mac_sum;
    logic signed [D_W-1:0]     mac_step;
    logic signed [A_W-1:0]     s_diff;
    logic signed [D_W-1:0]     env_diff;
    logic                      env_up;
    logic [ER_W-1:0]           a_red;
    logic                      div_ge;
    logic [ACC_W-1:0]          gacc_step;
    logic signed [OUT_W-1:0]   res_val;

    assign feed.ready        = (state_reg == ST_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.sample_out = out_data_reg;

    // One bit of coefficient per cycle, LSB first. Each right shift floors,
    // so after all bits the accumulator holds floor(d * c / 2^COEF_FRAC_BITS).
    assign mac_sum  = {macc_reg[D_W-1], macc_reg}
                    + (coef_sh_reg[0] ? {md_reg[D_W-1], md_reg} : {(D_W+1){1'b0}});
    assign mac_step = mac_sum[D_W:1];

    // Restoring divide step, quotient bits folded straight into the volume product.
    assign div_ge    = (rem_reg >= dsh_reg);
    assign gacc_step = {gacc_reg[ACC_W-2:0], 1'b0}
                     + (div_ge ? ACC_W'(volume_reg) : {ACC_W{1'b0}});

    assign x_new  = {feed.sample_in, {STATE_EXTRA{1'b0}}};
    assign x_ext  = {{2{x_new[S_W-1]}}, x_new};
    assign dc_ext = {{2{dc_reg[S_W-1]}}, dc_reg};

    assign s_diff   = {x_reg[S_W-1], x_reg} - {dc_reg[S_W-1], dc_reg};
    assign env_diff = {1'b0, a_reg} - {1'b0, env_reg};
    assign env_up   = !env_diff[D_W-1] && (env_diff != '0);
    assign a_red    = a_reg[A_W-1:RED_SHIFT];

    // Sign applied after the volume, then clamp to Q0.15.
    always_comb
    begin
        if (neg_reg)
        begin
            res_val = g_reg[VOL_W-1] ? OUT_NEG_LIM : (~g_reg + 1'b1);
        end
        else
        begin
            res_val = g_reg[VOL_W-1] ? OUT_POS_LIM : g_reg;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath updates
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        dc_next        = dc_reg;
        env_next       = env_reg;
        a_next         = a_reg;
        neg_next       = neg_reg;
        md_next        = md_reg;
        macc_next      = macc_reg;
        coef_sh_next   = coef_sh_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        gacc_next      = gacc_reg;
        g_next         = g_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (feed.valid)
                begin
                    x_next       = x_new;
                    md_next      = x_ext - dc_ext;
                    macc_next    = '0;
                    coef_sh_next = dc_coef_reg;
                    cnt_next     = '0;
                    state_next   = ST_DC_MUL;
                end
            end

            ST_DC_MUL:
            begin
                macc_next    = mac_step;
                coef_sh_next = coef_sh_reg >> 1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(COEF_FRAC_BITS - 1))
                begin
                    state_next = ST_DC_ADD;
                end
            end

            ST_DC_ADD:
            begin
                dc_next    = dc_reg + macc_reg[S_W-1:0];
                state_next = ST_ABS;
            end

            ST_ABS:
            begin
                neg_next   = s_diff[A_W-1];
                a_next     = s_diff[A_W-1] ? unsigned'(-s_diff) : unsigned'(s_diff);
                state_next = ST_ENV_SET;
            end

            ST_ENV_SET:
            begin
                // attack while the level is above the envelope
                md_next      = env_diff;
                macc_next    = '0;
                coef_sh_next = env_up ? attack_coef_reg : release_coef_reg;
                cnt_next     = '0;
                state_next   = ST_ENV_MUL;
            end

            ST_ENV_MUL:
            begin
                macc_next    = mac_step;
                coef_sh_next = coef_sh_reg >> 1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(COEF_FRAC_BITS - 1))
                begin
                    state_next = ST_ENV_ADD;
                end
            end

            ST_ENV_ADD:
            begin
                env_next   = env_reg + macc_reg[A_W-1:0];
                state_next = ST_ENV_FLOOR;
            end

            ST_ENV_FLOOR:
            begin
                if (env_reg < ENV_ONE)
                begin
                    env_next = ENV_ONE;
                end
                state_next = ST_DIV_PREP;
            end

            ST_DIV_PREP:
            begin
                // num = level * 0.6; first compare is against 2*env << 15
                rem_next   = NUM_W'(a_red) * NUM_W'(GAIN_06_Q16);
                dsh_next   = {env_reg[A_W-1:RED_SHIFT], {GAIN_W{1'b0}}};
                gacc_next  = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if ((cnt_reg == '0) && div_ge)
                begin
                    // ratio reaches 1.0: full scale times volume
                    g_next     = volume_reg;
                    state_next = ST_FINISH;
                end
                else
                begin
                    if (div_ge)
                    begin
                        rem_next = rem_reg - dsh_reg;
                    end
                    dsh_next  = dsh_reg >> 1;
                    gacc_next = gacc_step;
                    cnt_next  = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        g_next     = gacc_step[ACC_W-1:ACC_W-VOL_W];
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                // wait here only while the previous result is still unclaimed
                if (!out_valid_reg || result.ready)
                begin
                    out_data_next  = res_val;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control and filter state, reset
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
            dc_reg           <= '0;
            env_reg          <= '0;
            dc_coef_reg      <= COEF_FRAC_BITS'(RST_DC_COEF);
            attack_coef_reg  <= COEF_FRAC_BITS'(RST_ATTACK_COEF);
            release_coef_reg <= COEF_FRAC_BITS'(RST_RELEASE_COEF);
            volume_reg       <= VOL_W'(RST_OUT_VOLUME);
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            dc_reg        <= dc_next;
            env_reg       <= env_next;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_DC_COEF:      dc_coef_reg      <= cfg_wdata;
                    REG_ATTACK_COEF:  attack_coef_reg  <= cfg_wdata;
                    REG_RELEASE_COEF: release_coef_reg <= cfg_wdata;
                    REG_OUT_VOLUME:   volume_reg       <= cfg_wdata[VOL_W-1:0];
                    default:
                    begin
                        // unmapped index: ignored
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers, no reset
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        a_reg        <= a_next;
        neg_reg      <= neg_next;
        md_reg       <= md_next;
        macc_reg     <= macc_next;
        coef_sh_reg  <= coef_sh_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        gacc_reg     <= gacc_next;
        g_reg        <= g_next;
        out_data_reg <= out_data_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `DBEL_ASSERT_NEXT(a_start_dc_mul, clk, rst_n, feed.valid && feed.ready, (state_reg == ST_DC_MUL) && (cnt_reg == '0), "transfer did not start the DC multiply")
    `DBEL_ASSERT_NOW(a_env_floored, clk, rst_n, state_reg == ST_DIV_PREP, env_reg >= ENV_ONE, "envelope below 1.0 at divide")
    `DBEL_ASSERT_NOW(a_div_rem_bound, clk, rst_n, (state_reg == ST_DIV) && (cnt_reg != '0), ({1'b0, rem_reg} < {dsh_reg, 1'b0}), "divide remainder out of range")
    `DBEL_ASSERT_NEXT(a_finish_loads, clk, rst_n, (state_reg == ST_FINISH) && !out_valid_reg, out_valid_reg && (state_reg == ST_IDLE), "result not loaded into empty output register")

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the DC blocker / envelope limiter.
// Samples are fed from a backlog queue by a clocked driver. Each accepted
// transfer runs through a bit-exact conditioner model. The monitor compares
// every output transfer against the oldest predicted sample.
module testbench
    import dbel_pkg::*;
();

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 24;

    // Drain time after the last phase: one sample's run through the block, plus slack.
    localparam int SETTLE_CYCLES = 2 * COEF_BITS + 32;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_ITEMS   = 180;
    localparam int RANDOM_PHASES = 9;

    localparam longint SAMPLE_MAX  = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN  = -SAMPLE_MAX - 1;
    localparam longint UNITY_LEVEL = longint'(1) << (SAMPLE_FRAC + STATE_EXTRA);
    localparam logic [COEF_BITS-1:0] RATE_MAX = '1;
    localparam logic [VOL_W-1:0]     GAIN_MAX = '1;

    // Waveform families used to build the random sample program.
    typedef enum int {
        SHAPE_NOISE,
        SHAPE_SQUARE,
        SHAPE_RAMP,
        SHAPE_OFFSET,
        SHAPE_SILENCE,
        SHAPE_RAIL
    } wave_shape_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [COEF_BITS-1:0]   cfg_wdata;

    dbel_sample_in_if #(.SAMPLE_WIDTH(SAMPLE_BITS)) feed_bus ();
    dbel_sample_out_if result_bus ();

    dc_block_envelope_limiter_top #(
        .SAMPLE_WIDTH   (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .feed      (feed_bus),
        .result    (result_bus)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Conditioner model: register copy and tracker state, reset values.
    logic [COEF_BITS-1:0] dc_rate   = COEF_BITS'(RST_DC_COEF);
    logic [COEF_BITS-1:0] rise_rate = COEF_BITS'(RST_ATTACK_COEF);
    logic [COEF_BITS-1:0] fall_rate = COEF_BITS'(RST_RELEASE_COEF);
    logic [VOL_W-1:0]     out_gain  = VOL_W'(RST_OUT_VOLUME);
    longint dc_track  = 0;
    longint env_track = 0;

    logic signed [SAMPLE_BITS-1:0] sample_backlog[$];
    logic signed [OUT_W-1:0]       sample_expect[$];

    int   failures = 0;
    int   samples_fed = 0;
    int   results_checked = 0;
    int   settings_used = 0;
    int   cycles = 0;
    int   feed_gap;
    int   drain_gap;
    logic feed_bursts = 1'b1;
    logic drain_bursts = 1'b1;
    logic quiet_tail = 1'b0;

    // floor(diff * rate / 2^COEF_BITS), exact: the product needs ~72 bits.
    function automatic longint scale_by_rate(longint diff, logic [COEF_BITS-1:0] rate);
        logic signed [95:0] prod;
        prod = diff;
        prod = prod * $signed({{(96 - COEF_BITS){1'b0}}, rate});
        return longint'(prod >>> COEF_BITS);
    endfunction

    // Advances the DC tracker and envelope by one sample and returns the
    // conditioned Q0.15 output.
    function automatic logic signed [OUT_W-1:0] condition_sample(
        logic signed [SAMPLE_BITS-1:0] smp);
        longint x, s, a, lvl, env_r, num, mag, g;
        x = longint'(smp) * (longint'(1) << STATE_EXTRA);
        dc_track += scale_by_rate(x - dc_track, dc_rate);
        s = x - dc_track;
        a = (s < 0) ? -s : s;
        // attack while the level sits above the envelope, release otherwise
        if (a > env_track)
            env_track += scale_by_rate(a - env_track, rise_rate);
        else
            env_track += scale_by_rate(a - env_track, fall_rate);
        if (env_track < UNITY_LEVEL)
            env_track = UNITY_LEVEL;
        lvl   = a >>> RED_SHIFT;
        env_r = env_track >>> RED_SHIFT;
        num   = lvl * GAIN_06_Q16;
        // limiter clips to full scale once 0.6*level reaches the envelope
        if (num >= (env_r <<< 16))
            mag = 32768;
        else
            mag = num / (2 * env_r);
        // sign goes on after the volume, so truncation is symmetric
        g = (mag * longint'(out_gain)) >>> 15;
        if (s < 0)
            g = -g;
        if (g > longint'(OUT_POS_LIM))
            g = longint'(OUT_POS_LIM);
        if (g < longint'(OUT_NEG_LIM))
            g = longint'(OUT_NEG_LIM);
        return OUT_W'(g);
    endfunction

    // Appends one sample to the end of the backlog.
    task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] smp);
        sample_backlog = {sample_backlog, smp};
    endtask

    // Register write; the model copy follows. Only called while idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [COEF_BITS-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            REG_DC_COEF:      dc_rate = data;
            REG_ATTACK_COEF:  rise_rate = data;
            REG_RELEASE_COEF: fall_rate = data;
            REG_OUT_VOLUME:   out_gain = data[VOL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [COEF_BITS-1:0] dc,
                                  input logic [COEF_BITS-1:0] rise,
                                  input logic [COEF_BITS-1:0] fall,
                                  input logic [COEF_BITS-1:0] gain);
        write_register(REG_DC_COEF, dc);
        write_register(REG_ATTACK_COEF, rise);
        write_register(REG_RELEASE_COEF, fall);
        write_register(REG_OUT_VOLUME, gain);
        settings_used++;
    endtask

    // Idle means: nothing queued, nothing on the bus, nothing outstanding.
    // Checked on the falling edge so all edge updates have settled.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (sample_backlog.size() != 0 || sample_expect.size() != 0 || feed_bus.valid);
    endtask

    // Mix of slow realistic rates, tiny rates, full range and the extremes.
    function automatic logic [COEF_BITS-1:0] pick_rate();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return RATE_MAX;
            2: return COEF_BITS'($urandom_range(1, 255));
            3: return COEF_BITS'($urandom_range(1, 1 << 17));
            default: return COEF_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_BITS-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return COEF_BITS'(GAIN_MAX);
            2: return COEF_BITS'(RST_OUT_VOLUME);
            // upper bits random too: the block must drop them
            default: return COEF_BITS'($urandom);
        endcase
    endfunction

    // Appends count samples made of short waveform segments with random
    // amplitude, offset and period, plus some raw noise.
    task automatic queue_program(input int count);
        wave_shape_t shape;
        int     span, period;
        longint amp, offset, level;
        while (count > 0)
        begin
            shape  = wave_shape_t'($urandom_range(0, 5));
            span   = $urandom_range(8, 64);
            period = $urandom_range(2, 40);
            amp    = longint'($urandom_range(0, 8388607)) >> $urandom_range(0, 16);
            offset = (longint'($urandom_range(0, 16777215)) - 8388608)
                     >>> $urandom_range(0, 20);
            if (span > count)
                span = count;
            for (int i = 0; i < span; i++)
            begin
                case (shape)
                    SHAPE_NOISE:   level = longint'($urandom_range(0, 16777215)) - 8388608;
                    SHAPE_SQUARE:  level = offset + (((i / period) % 2 != 0) ? amp : -amp);
                    SHAPE_RAMP:    level = offset - amp + (2 * amp * (i % period)) / period;
                    SHAPE_OFFSET:  level = offset + longint'($urandom_range(0, 511)) - 256;
                    SHAPE_SILENCE: level = 0;
                    default:       level = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
                endcase
                if (level > SAMPLE_MAX)
                    level = SAMPLE_MAX;
                if (level < SAMPLE_MIN)
                    level = SAMPLE_MIN;
                queue_sample(SAMPLE_BITS'(level));
            end
            count -= span;
        end
    endtask

    // Driver: presents the backlog on the feed channel. A new sample or a
    // gap is chosen only when no transfer is pending, so valid holds until
    // accepted. The model runs at the accepting edge.
    always @(posedge clk or negedge rst_n)
    begin
        logic holding;
        logic signed [OUT_W-1:0] predicted;
        if (!rst_n)
        begin
            feed_bus.valid     <= 1'b0;
            feed_bus.sample_in <= '0;
            feed_gap = 0;
        end
        else
        begin
            holding = feed_bus.valid;
            if (feed_bus.valid && feed_bus.ready)
            begin
                predicted = condition_sample(feed_bus.sample_in);
                sample_expect = {sample_expect, predicted};
                samples_fed++;
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (feed_gap == 0 && feed_bursts && !quiet_tail && $urandom_range(0, 4) == 0)
                    feed_gap = $urandom_range(1, 9);
                if (feed_gap > 0)
                begin
                    feed_gap--;
                    feed_bus.valid <= 1'b0;
                end
                else if (sample_backlog.size() > 0)
                begin
                    feed_bus.valid     <= 1'b1;
                    feed_bus.sample_in <= sample_backlog.pop_front();
                end
                else
                    feed_bus.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each output transfer, then picks ready for the next
    // cycle, stalling in random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        logic signed [OUT_W-1:0] wanted;
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            drain_gap = 0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (sample_expect.size() == 0)
                begin
                    $error("sample_out: transfer with nothing expected, actual %0d",
                           result_bus.sample_out);
                    failures++;
                end
                else
                begin
                    wanted = sample_expect.pop_front();
                    if (result_bus.sample_out !== wanted)
                    begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               wanted, result_bus.sample_out);
                        failures++;
                    end
                    results_checked++;
                end
            end
            if (drain_gap == 0 && drain_bursts && !quiet_tail && $urandom_range(0, 5) == 0)
                drain_gap = $urandom_range(1, 9);
            if (drain_gap > 0)
            begin
                drain_gap--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    // Watchdog; also flips the burst modes now and then so that long
    // stretches run with no gaps or stalls at all.
    always @(posedge clk)
    begin
        cycles++;
        if ($urandom_range(0, 249) == 0)
            feed_bursts <= ~feed_bursts;
        if ($urandom_range(0, 249) == 0)
            drain_bursts <= ~drain_bursts;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, sample_expect.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        cfg_we              = 1'b0;
        cfg_index           = REG_DC_COEF;
        cfg_wdata           = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Writes to indexes past the last register must change nothing;
        // the default-setting samples below would show it.
        for (int idx = int'(REG_OUT_VOLUME) + 1; idx < (1 << CFG_IDX_W); idx++)
            write_register(CFG_IDX_W'(idx), COEF_BITS'($urandom));

        // Directed, reset settings: rails, unity, tiny values, envelope
        // build-up and release, a few zeros to let it decay.
        queue_sample(SAMPLE_BITS'(0));
        queue_sample(SAMPLE_BITS'(SAMPLE_MAX));
        queue_sample(SAMPLE_BITS'(SAMPLE_MIN));
        queue_sample(SAMPLE_BITS'(SAMPLE_MAX));
        queue_sample(SAMPLE_BITS'(SAMPLE_MIN));
        queue_sample(SAMPLE_BITS'(65536));
        queue_sample(SAMPLE_BITS'(-65536));
        queue_sample(SAMPLE_BITS'(1));
        queue_sample(SAMPLE_BITS'(-1));
        queue_sample(SAMPLE_BITS'(39322));
        queue_sample(SAMPLE_BITS'(0));
        queue_sample(SAMPLE_BITS'(0));
        wait_idle();

        // Zero rates: trackers hold. Volume written with junk above bit 15.
        apply_settings('0, '0, '0, 24'hFF8000);
        queue_sample(SAMPLE_BITS'(SAMPLE_MAX));
        queue_sample(SAMPLE_BITS'(-1));
        queue_sample(SAMPLE_BITS'(131072));
        queue_sample(SAMPLE_BITS'(SAMPLE_MIN));
        queue_sample(SAMPLE_BITS'(0));
        queue_sample(SAMPLE_BITS'(4096));
        wait_idle();

        // Full rates and maximum gain on rail and small samples.
        apply_settings(RATE_MAX, RATE_MAX, RATE_MAX, COEF_BITS'(GAIN_MAX));
        queue_sample(SAMPLE_BITS'(SAMPLE_MAX));
        queue_sample(SAMPLE_BITS'(SAMPLE_MIN));
        queue_sample(SAMPLE_BITS'(65536));
        queue_sample(SAMPLE_BITS'(-65536));
        queue_sample(SAMPLE_BITS'(0));
        queue_sample(SAMPLE_BITS'(-32768));
        wait_idle();

        // Random program, one register setting per phase. The first three
        // phases pin realistic defaults and the two corners; the last one
        // runs with no gaps or stalls.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                apply_settings(COEF_BITS'(RST_DC_COEF), COEF_BITS'(RST_ATTACK_COEF),
                               COEF_BITS'(RST_RELEASE_COEF), pick_gain());
            else if (phase == 1)
                apply_settings('0, RATE_MAX, COEF_BITS'(1), '0);
            else if (phase == 2)
                apply_settings(RATE_MAX, RATE_MAX, RATE_MAX, COEF_BITS'(GAIN_MAX));
            else
                apply_settings(pick_rate(), pick_rate(), pick_rate(), pick_gain());
            if (phase == RANDOM_PHASES - 1)
                quiet_tail = 1'b1;
            queue_program(PHASE_ITEMS);
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sample_expect.size() != 0)
        begin
            $error("sample_out: %0d expected samples never arrived", sample_expect.size());
            failures++;
        end
        $display("Conditioned %0d samples over %0d register settings, %0d outputs compared",
                 samples_fed, settings_used, results_checked);
        $display("Stimulus: rails, noise, square, ramp, offset and silence segments");
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/dbel_pkg.sv
rtl/core/dbel_sample_in_if.sv
rtl/core/dbel_sample_out_if.sv
rtl/core/dc_block_envelope_limiter_top.sv
sim/testbench.sv
